// File: rtl/rpfnh_pkg.sv
// ----------------------------------------------------------------------------
// rpfnh_pkg
// Types, widths, codes and the multiply program for the ray/polygon picker.
// ----------------------------------------------------------------------------
package rpfnh_pkg;

    localparam int COORD_W     = 32;
    localparam int VEC_W       = 33;
    localparam int WIDE_W      = 128;
    localparam int DIST_W      = 40;
    localparam int EPS_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int MUL_BITS    = 33;
    localparam int BIT_CNT_W   = 6;
    localparam int NUM_UOPS    = 24;
    localparam int UOP_W       = 5;
    localparam int DIV_STEPS   = 128;
    localparam int DIV_CNT_W   = 7;
    localparam int FRAC_SHIFT  = 16;
    localparam int MAX_CORNERS_DEF = 255;

    localparam logic [COORD_W-1:0] DIR_Z_RST = 32'd65536;
    localparam logic [DIST_W-1:0]  MAXD_RST  = 40'd65536000000;
    localparam logic [EPS_W-1:0]   EPS_RST   = 32'd2814750;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORG_X = 3'd0,
        CFG_ORG_Y = 3'd1,
        CFG_ORG_Z = 3'd2,
        CFG_DIR_X = 3'd3,
        CFG_DIR_Y = 3'd4,
        CFG_DIR_Z = 3'd5,
        CFG_MAXD  = 3'd6,
        CFG_EPS   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NEG,
        ST_CHECK,
        ST_DIV,
        ST_CMP,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        A_D0, A_D1, A_D2, A_TV0, A_TV1, A_TV2,
        A_P0, A_P1, A_P2, A_Q0, A_Q1, A_Q2
    } asel_t;

    typedef enum logic [3:0] {
        B_E10, B_E11, B_E12, B_E20, B_E21, B_E22,
        B_D0, B_D1, B_D2, B_TV0, B_TV1, B_TV2
    } bsel_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_P0, DST_P1, DST_P2, DST_DET, DST_UN,
        DST_Q0, DST_Q1, DST_Q2, DST_VN, DST_TN
    } dest_t;

    typedef struct packed {
        asel_t a_sel;
        bsel_t b_sel;
        logic  sub;
        logic  first;
        dest_t dest;
    } uop_t;

    function automatic uop_t get_uop(input logic [UOP_W-1:0] idx);
        uop_t u;
        u = '{a_sel: A_D0, b_sel: B_E10, sub: 1'b0, first: 1'b0, dest: DST_NONE};
        case (idx)
            5'd0:  u = '{A_D1,  B_E22, 1'b0, 1'b1, DST_NONE};
            5'd1:  u = '{A_D2,  B_E21, 1'b1, 1'b0, DST_P0};
            5'd2:  u = '{A_D2,  B_E20, 1'b0, 1'b1, DST_NONE};
            5'd3:  u = '{A_D0,  B_E22, 1'b1, 1'b0, DST_P1};
            5'd4:  u = '{A_D0,  B_E21, 1'b0, 1'b1, DST_NONE};
            5'd5:  u = '{A_D1,  B_E20, 1'b1, 1'b0, DST_P2};
            5'd6:  u = '{A_P0,  B_E10, 1'b0, 1'b1, DST_NONE};
            5'd7:  u = '{A_P1,  B_E11, 1'b0, 1'b0, DST_NONE};
            5'd8:  u = '{A_P2,  B_E12, 1'b0, 1'b0, DST_DET};
            5'd9:  u = '{A_P0,  B_TV0, 1'b0, 1'b1, DST_NONE};
            5'd10: u = '{A_P1,  B_TV1, 1'b0, 1'b0, DST_NONE};
            5'd11: u = '{A_P2,  B_TV2, 1'b0, 1'b0, DST_UN};
            5'd12: u = '{A_TV1, B_E12, 1'b0, 1'b1, DST_NONE};
            5'd13: u = '{A_TV2, B_E11, 1'b1, 1'b0, DST_Q0};
            5'd14: u = '{A_TV2, B_E10, 1'b0, 1'b1, DST_NONE};
            5'd15: u = '{A_TV0, B_E12, 1'b1, 1'b0, DST_Q1};
            5'd16: u = '{A_TV0, B_E11, 1'b0, 1'b1, DST_NONE};
            5'd17: u = '{A_TV1, B_E10, 1'b1, 1'b0, DST_Q2};
            5'd18: u = '{A_Q0,  B_D0,  1'b0, 1'b1, DST_NONE};
            5'd19: u = '{A_Q1,  B_D1,  1'b0, 1'b0, DST_NONE};
            5'd20: u = '{A_Q2,  B_D2,  1'b0, 1'b0, DST_VN};
            5'd21: u = '{A_Q0,  B_E20, 1'b0, 1'b1, DST_NONE};
            5'd22: u = '{A_Q1,  B_E21, 1'b0, 1'b0, DST_NONE};
            5'd23: u = '{A_Q2,  B_E22, 1'b0, 1'b0, DST_TN};
            default: u = '{A_D0, B_E10, 1'b0, 1'b1, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

// File: rtl/rpfnh_if.sv
// ----------------------------------------------------------------------------
// rpfnh_if
// Vertex and result channels with valid/ready transactions.
// ----------------------------------------------------------------------------
interface rpfnh_vertex_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpfnh_pkg::COORD_W-1:0] vertex_x;
    logic signed [rpfnh_pkg::COORD_W-1:0] vertex_y;
    logic signed [rpfnh_pkg::COORD_W-1:0] vertex_z;
    logic                               last_corner;

    modport source (output valid, vertex_x, vertex_y, vertex_z, last_corner, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_corner, output ready);
endinterface

interface rpfnh_result_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [rpfnh_pkg::DIST_W-1:0]    distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

// File: rtl/ray_polygon_fan_nearest_hit.sv
// Sequence: a corner that closes no triangle goes straight to finish; a fan triangle
//   runs 24 micro-ops on the shared serial multiply-accumulate unit, sign fix, check,
//   the restoring divider and compare; a zero det or a rejection skips to finish.
// Throughput: one corner at a time; ready is low while a corner is in work.
// Reset: rst_n clears the sequencer, counters and result valid, and loads the
//   configuration registers with their defaults.
// ----------------------------------------------------------------------------
// ray_polygon_fan_nearest_hit
// Nearest ray hit over a polygon's triangle fan using a shared serial MAC.
// ----------------------------------------------------------------------------
module ray_polygon_fan_nearest_hit #(
    parameter int MAX_CORNERS = rpfnh_pkg::MAX_CORNERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rpfnh_vertex_if.sink                        vtx,
    rpfnh_result_if.source                      res,
    input  logic                                cfg_we,
    input  logic [rpfnh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpfnh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam int VW = rpfnh_pkg::VEC_W;
    localparam int WW = rpfnh_pkg::WIDE_W;
    localparam int DW = rpfnh_pkg::DIST_W;
    localparam int XW = rpfnh_pkg::COORD_W;

    rpfnh_pkg::state_t state_reg, state_next;

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [rpfnh_pkg::UOP_W-1:0]     uidx_reg, uidx_next;
    logic [rpfnh_pkg::BIT_CNT_W-1:0] bcnt_reg, bcnt_next;
    logic [rpfnh_pkg::DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    logic signed [XW-1:0] org_reg [3];
    logic signed [XW-1:0] dir_reg [3];
    logic [DW-1:0]        maxd_reg;
    logic [rpfnh_pkg::EPS_W-1:0] eps_reg;

    logic signed [XW-1:0] first_reg [3], first_next [3];
    logic signed [XW-1:0] prev_reg [3], prev_next [3];
    logic signed [VW-1:0] e1_reg [3], e1_next [3];
    logic signed [VW-1:0] e2_reg [3], e2_next [3];
    logic signed [VW-1:0] tv_reg [3], tv_next [3];
    logic signed [VW-1:0] dv_reg [3], dv_next [3];
    logic [WW-1:0] p_reg [3], p_next [3];
    logic [WW-1:0] q_reg [3], q_next [3];
    logic [WW-1:0] det_reg, det_next, un_reg, un_next, vn_reg, vn_next, tn_reg, tn_next;
    logic [WW-1:0] acc_reg, acc_next, ash_reg, ash_next;
    logic [VW-1:0] bsh_reg, bsh_next;
    logic [WW-1:0] rem_reg, rem_next, quo_reg, quo_next;
    logic [DW-1:0] best_reg, best_next;
    logic          any_reg, any_next, last_reg, last_next;
    logic          ovld_reg, ovld_next, ohit_reg, ohit_next;
    logic [DW-1:0] odist_reg, odist_next;

    rpfnh_pkg::uop_t uop;
    logic [WW-1:0]   a_val, acc_sum, rem2, sum_uv;
    logic [VW-1:0]   b_val;
    logic            in_acc, out_load, mul_done, reject, div_ge;
    logic signed [VW-1:0] vin [3];

    assign in_acc  = vtx.valid && vtx.ready;
    assign uop     = rpfnh_pkg::get_uop(uidx_reg);
    assign mul_done = (bcnt_reg == rpfnh_pkg::BIT_CNT_W'(rpfnh_pkg::MUL_BITS));
    assign vin[0]  = VW'(vtx.vertex_x);
    assign vin[1]  = VW'(vtx.vertex_y);
    assign vin[2]  = VW'(vtx.vertex_z);

    always_comb
    begin
        case (uop.a_sel)
            rpfnh_pkg::A_D0:  a_val = WW'(dv_reg[0]);
            rpfnh_pkg::A_D1:  a_val = WW'(dv_reg[1]);
            rpfnh_pkg::A_D2:  a_val = WW'(dv_reg[2]);
            rpfnh_pkg::A_TV0: a_val = WW'(tv_reg[0]);
            rpfnh_pkg::A_TV1: a_val = WW'(tv_reg[1]);
            rpfnh_pkg::A_TV2: a_val = WW'(tv_reg[2]);
            rpfnh_pkg::A_P0:  a_val = p_reg[0];
            rpfnh_pkg::A_P1:  a_val = p_reg[1];
            rpfnh_pkg::A_P2:  a_val = p_reg[2];
            rpfnh_pkg::A_Q0:  a_val = q_reg[0];
            rpfnh_pkg::A_Q1:  a_val = q_reg[1];
            rpfnh_pkg::A_Q2:  a_val = q_reg[2];
            default:          a_val = '0;
        endcase
        case (uop.b_sel)
            rpfnh_pkg::B_E10: b_val = e1_reg[0];
            rpfnh_pkg::B_E11: b_val = e1_reg[1];
            rpfnh_pkg::B_E12: b_val = e1_reg[2];
            rpfnh_pkg::B_E20: b_val = e2_reg[0];
            rpfnh_pkg::B_E21: b_val = e2_reg[1];
            rpfnh_pkg::B_E22: b_val = e2_reg[2];
            rpfnh_pkg::B_D0:  b_val = dv_reg[0];
            rpfnh_pkg::B_D1:  b_val = dv_reg[1];
            rpfnh_pkg::B_D2:  b_val = dv_reg[2];
            rpfnh_pkg::B_TV0: b_val = tv_reg[0];
            rpfnh_pkg::B_TV1: b_val = tv_reg[1];
            rpfnh_pkg::B_TV2: b_val = tv_reg[2];
            default:          b_val = '0;
        endcase
    end

    // serial MAC step: sign bit of the multiplier weighs negative
    always_comb
    begin
        acc_sum = acc_reg;
        if (bsh_reg[0])
        begin
            if (uop.sub ^ mul_done)
                acc_sum = acc_reg - ash_reg;
            else
                acc_sum = acc_reg + ash_reg;
        end
    end

    assign rem2   = {rem_reg[WW-2:0], quo_reg[WW-1]};
    assign div_ge = (rem2 >= det_reg);
    assign sum_uv = un_reg + vn_reg;
    assign reject = (det_reg < WW'(eps_reg)) || un_reg[WW-1] || (un_reg > det_reg)
                 || vn_reg[WW-1] || (sum_uv > det_reg) || tn_reg[WW-1];
    assign out_load = (state_reg == rpfnh_pkg::ST_FINISH) && last_reg
                   && (!ovld_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpfnh_pkg::ST_IDLE:
                if (in_acc)
                    state_next = (cnt_reg >= CW'(2)) ? rpfnh_pkg::ST_MUL : rpfnh_pkg::ST_FINISH;
            rpfnh_pkg::ST_MUL:
                if (mul_done && uidx_reg == rpfnh_pkg::UOP_W'(rpfnh_pkg::NUM_UOPS - 1))
                    state_next = rpfnh_pkg::ST_NEG;
            rpfnh_pkg::ST_NEG:
                state_next = (det_reg == '0) ? rpfnh_pkg::ST_FINISH : rpfnh_pkg::ST_CHECK;
            rpfnh_pkg::ST_CHECK:
                state_next = reject ? rpfnh_pkg::ST_FINISH : rpfnh_pkg::ST_DIV;
            rpfnh_pkg::ST_DIV:
                if (dcnt_reg == rpfnh_pkg::DIV_CNT_W'(rpfnh_pkg::DIV_STEPS - 1))
                    state_next = rpfnh_pkg::ST_CMP;
            rpfnh_pkg::ST_CMP:
                state_next = rpfnh_pkg::ST_FINISH;
            rpfnh_pkg::ST_FINISH:
                if (!last_reg || out_load)
                    state_next = rpfnh_pkg::ST_IDLE;
            default:
                state_next = rpfnh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        uidx_next = uidx_reg;
        bcnt_next = bcnt_reg;
        dcnt_next = dcnt_reg;
        first_next = first_reg;
        prev_next = prev_reg;
        e1_next = e1_reg;
        e2_next = e2_reg;
        tv_next = tv_reg;
        dv_next = dv_reg;
        p_next = p_reg;
        q_next = q_reg;
        det_next = det_reg;
        un_next = un_reg;
        vn_next = vn_reg;
        tn_next = tn_reg;
        acc_next = acc_reg;
        ash_next = ash_reg;
        bsh_next = bsh_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        best_next = best_reg;
        any_next = any_reg;
        last_next = last_reg;
        ohit_next = ohit_reg;
        odist_next = odist_reg;
        ovld_next = ovld_reg && !res.ready;
        case (state_reg)
            rpfnh_pkg::ST_IDLE:
                if (in_acc)
                begin
                    if (cnt_reg == '0)
                    begin
                        best_next = maxd_reg;
                        any_next = 1'b0;
                        first_next[0] = vtx.vertex_x;
                        first_next[1] = vtx.vertex_y;
                        first_next[2] = vtx.vertex_z;
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_next[i] = VW'(prev_reg[i]) - VW'(first_reg[i]);
                        e2_next[i] = vin[i] - VW'(first_reg[i]);
                        tv_next[i] = VW'(org_reg[i]) - VW'(first_reg[i]);
                        dv_next[i] = VW'(dir_reg[i]);
                    end
                    prev_next[0] = vtx.vertex_x;
                    prev_next[1] = vtx.vertex_y;
                    prev_next[2] = vtx.vertex_z;
                    if (cnt_reg < CW'(MAX_CORNERS))
                        cnt_next = cnt_reg + CW'(1);
                    last_next = vtx.last_corner;
                    uidx_next = '0;
                    bcnt_next = '0;
                end
            rpfnh_pkg::ST_MUL:
                if (bcnt_reg == '0)
                begin
                    ash_next = a_val;
                    bsh_next = b_val;
                    if (uop.first)
                        acc_next = '0;
                    bcnt_next = bcnt_reg + rpfnh_pkg::BIT_CNT_W'(1);
                end
                else
                begin
                    acc_next = acc_sum;
                    ash_next = {ash_reg[WW-2:0], 1'b0};
                    bsh_next = {1'b0, bsh_reg[VW-1:1]};
                    if (mul_done)
                    begin
                        bcnt_next = '0;
                        uidx_next = uidx_reg + rpfnh_pkg::UOP_W'(1);
                        case (uop.dest)
                            rpfnh_pkg::DST_P0:  p_next[0] = acc_sum;
                            rpfnh_pkg::DST_P1:  p_next[1] = acc_sum;
                            rpfnh_pkg::DST_P2:  p_next[2] = acc_sum;
                            rpfnh_pkg::DST_DET: det_next = acc_sum;
                            rpfnh_pkg::DST_UN:  un_next = acc_sum;
                            rpfnh_pkg::DST_Q0:  q_next[0] = acc_sum;
                            rpfnh_pkg::DST_Q1:  q_next[1] = acc_sum;
                            rpfnh_pkg::DST_Q2:  q_next[2] = acc_sum;
                            rpfnh_pkg::DST_VN:  vn_next = acc_sum;
                            rpfnh_pkg::DST_TN:  tn_next = acc_sum;
                            default:            acc_next = acc_sum;
                        endcase
                    end
                    else
                        bcnt_next = bcnt_reg + rpfnh_pkg::BIT_CNT_W'(1);
                end
            rpfnh_pkg::ST_NEG:
                if (det_reg[WW-1])
                begin
                    det_next = -det_reg;
                    un_next = -un_reg;
                    vn_next = -vn_reg;
                    tn_next = -tn_reg;
                end
            rpfnh_pkg::ST_CHECK:
            begin
                rem_next = '0;
                quo_next = tn_reg << rpfnh_pkg::FRAC_SHIFT;
                dcnt_next = '0;
            end
            rpfnh_pkg::ST_DIV:
            begin
                rem_next = div_ge ? (rem2 - det_reg) : rem2;
                quo_next = {quo_reg[WW-2:0], div_ge};
                dcnt_next = dcnt_reg + rpfnh_pkg::DIV_CNT_W'(1);
            end
            rpfnh_pkg::ST_CMP:
                if (quo_reg < WW'(best_reg))
                begin
                    best_next = quo_reg[DW-1:0];
                    any_next = 1'b1;
                end
            rpfnh_pkg::ST_FINISH:
                if (out_load)
                begin
                    ovld_next = 1'b1;
                    ohit_next = any_reg;
                    odist_next = any_reg ? best_reg : '0;
                    cnt_next = '0;
                    any_next = 1'b0;
                    best_next = maxd_reg;
                end
            default:
                ovld_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpfnh_pkg::ST_IDLE;
            cnt_reg <= '0;
            uidx_reg <= '0;
            bcnt_reg <= '0;
            dcnt_reg <= '0;
            any_reg <= 1'b0;
            last_reg <= 1'b0;
            ovld_reg <= 1'b0;
            best_reg <= rpfnh_pkg::MAXD_RST;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                first_reg[i] <= '0;
                prev_reg[i] <= '0;
            end
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= rpfnh_pkg::DIR_Z_RST;
            maxd_reg <= rpfnh_pkg::MAXD_RST;
            eps_reg <= rpfnh_pkg::EPS_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            uidx_reg <= uidx_next;
            bcnt_reg <= bcnt_next;
            dcnt_reg <= dcnt_next;
            any_reg <= any_next;
            last_reg <= last_next;
            ovld_reg <= ovld_next;
            best_reg <= best_next;
            first_reg <= first_next;
            prev_reg <= prev_next;
            if (cfg_we)
            begin
                case (rpfnh_pkg::cfg_idx_t'(cfg_index))
                    rpfnh_pkg::CFG_ORG_X: org_reg[0] <= cfg_data[XW-1:0];
                    rpfnh_pkg::CFG_ORG_Y: org_reg[1] <= cfg_data[XW-1:0];
                    rpfnh_pkg::CFG_ORG_Z: org_reg[2] <= cfg_data[XW-1:0];
                    rpfnh_pkg::CFG_DIR_X: dir_reg[0] <= cfg_data[XW-1:0];
                    rpfnh_pkg::CFG_DIR_Y: dir_reg[1] <= cfg_data[XW-1:0];
                    rpfnh_pkg::CFG_DIR_Z: dir_reg[2] <= cfg_data[XW-1:0];
                    rpfnh_pkg::CFG_MAXD:  maxd_reg <= cfg_data[DW-1:0];
                    rpfnh_pkg::CFG_EPS:   eps_reg <= cfg_data[rpfnh_pkg::EPS_W-1:0];
                    default:              eps_reg <= eps_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg <= e1_next;
        e2_reg <= e2_next;
        tv_reg <= tv_next;
        dv_reg <= dv_next;
        p_reg <= p_next;
        q_reg <= q_next;
        det_reg <= det_next;
        un_reg <= un_next;
        vn_reg <= vn_next;
        tn_reg <= tn_next;
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ohit_reg <= ohit_next;
        odist_reg <= odist_next;
    end

    assign vtx.ready    = (state_reg == rpfnh_pkg::ST_IDLE);
    assign res.valid    = ovld_reg;
    assign res.hit      = ohit_reg;
    assign res.distance = odist_reg;

endmodule

// File: rtl/rpfnh_checker.sv
// ----------------------------------------------------------------------------
// rpfnh_checker
// Port-level checks on the picker's vertex and result transactions.
// ----------------------------------------------------------------------------
module rpfnh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_hit,
    input logic [rpfnh_pkg::DIST_W-1:0]   out_distance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_hit) && $stable(out_distance))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_distance == '0)
        else $error("miss with nonzero distance");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("vertex taken while busy");

endmodule

bind ray_polygon_fan_nearest_hit rpfnh_checker u_rpfnh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (vtx.valid),
    .in_ready     (vtx.ready),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .out_hit      (res.hit),
    .out_distance (res.distance)
);
